FILE: rtl/ell_pkg.sv
// Shared types, token codes, character constants and character-class functions for the lexer.
package ell_pkg;

    localparam int CNT_BITS_DEF = 24;
    localparam int FIELD_W      = 24;
    localparam int KIND_W       = 5;
    localparam int SLOTS        = 3;

    localparam logic [KIND_W-1:0] TK_END     = 5'd0;
    localparam logic [KIND_W-1:0] TK_LPAREN  = 5'd1;
    localparam logic [KIND_W-1:0] TK_RPAREN  = 5'd2;
    localparam logic [KIND_W-1:0] TK_COMMA   = 5'd3;
    localparam logic [KIND_W-1:0] TK_HASH    = 5'd4;
    localparam logic [KIND_W-1:0] TK_PLUS    = 5'd5;
    localparam logic [KIND_W-1:0] TK_MINUS   = 5'd6;
    localparam logic [KIND_W-1:0] TK_STAR    = 5'd7;
    localparam logic [KIND_W-1:0] TK_SLASH   = 5'd8;
    localparam logic [KIND_W-1:0] TK_PERCENT = 5'd9;
    localparam logic [KIND_W-1:0] TK_TILDE   = 5'd10;
    localparam logic [KIND_W-1:0] TK_CARET   = 5'd11;
    localparam logic [KIND_W-1:0] TK_EQEQ    = 5'd12;
    localparam logic [KIND_W-1:0] TK_EQ      = 5'd13;
    localparam logic [KIND_W-1:0] TK_ASSIGN  = 5'd14;
    localparam logic [KIND_W-1:0] TK_OROR    = 5'd15;
    localparam logic [KIND_W-1:0] TK_OR      = 5'd16;
    localparam logic [KIND_W-1:0] TK_ANDAND  = 5'd17;
    localparam logic [KIND_W-1:0] TK_AND     = 5'd18;
    localparam logic [KIND_W-1:0] TK_LE      = 5'd19;
    localparam logic [KIND_W-1:0] TK_SHL     = 5'd20;
    localparam logic [KIND_W-1:0] TK_LT      = 5'd21;
    localparam logic [KIND_W-1:0] TK_GE      = 5'd22;
    localparam logic [KIND_W-1:0] TK_SHR     = 5'd23;
    localparam logic [KIND_W-1:0] TK_GT      = 5'd24;
    localparam logic [KIND_W-1:0] TK_NE      = 5'd25;
    localparam logic [KIND_W-1:0] TK_BANG    = 5'd26;
    localparam logic [KIND_W-1:0] TK_IDENT   = 5'd27;
    localparam logic [KIND_W-1:0] TK_INT     = 5'd28;
    localparam logic [KIND_W-1:0] TK_ERROR   = 5'd29;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [3:0] {
        MD_IDLE,
        MD_COMMENT,
        MD_IDENT,
        MD_INT,
        MD_EQ,
        MD_COLON,
        MD_BAR,
        MD_AMP,
        MD_LT,
        MD_GT,
        MD_BANG
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] off;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] col;
    } t_token;

    typedef struct packed {
        logic [SLOTS-1:0]   vld;
        t_token [SLOTS-1:0] tok;
    } t_tok_group;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {["a":"z"], ["A":"Z"], CH_UNDER});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {["0":"9"]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {" ", [8'd9:8'd13]});
    endfunction

    // TK_END means the byte is not a single-character operator
    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            ",":     k = TK_COMMA;
            "#":     k = TK_HASH;
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "*":     k = TK_STAR;
            "/":     k = TK_SLASH;
            "%":     k = TK_PERCENT;
            "~":     k = TK_TILDE;
            "^":     k = TK_CARET;
            default: k = TK_END;
        endcase
        return k;
    endfunction

    // MD_IDLE means the byte does not open a pending token
    function automatic t_mode start_mode(input logic [7:0] c);
        t_mode m;
        case (c)
            CH_EQ:    m = MD_EQ;
            CH_COLON: m = MD_COLON;
            CH_BAR:   m = MD_BAR;
            CH_AMP:   m = MD_AMP;
            CH_LT:    m = MD_LT;
            CH_GT:    m = MD_GT;
            CH_BANG:  m = MD_BANG;
            default: begin
                if (is_alpha(c)) begin
                    m = MD_IDENT;
                end else if (is_digit(c)) begin
                    m = MD_INT;
                end else begin
                    m = MD_IDLE;
                end
            end
        endcase
        return m;
    endfunction

    function automatic logic [KIND_W-1:0] lone_kind(input t_mode m);
        logic [KIND_W-1:0] k;
        case (m)
            MD_EQ:    k = TK_EQ;
            MD_BAR:   k = TK_OR;
            MD_AMP:   k = TK_AND;
            MD_LT:    k = TK_LT;
            MD_GT:    k = TK_GT;
            MD_BANG:  k = TK_BANG;
            MD_IDENT: k = TK_IDENT;
            MD_INT:   k = TK_INT;
            default:  k = TK_ERROR;
        endcase
        return k;
    endfunction

    // TK_END means the byte does not complete a two-character operator
    function automatic logic [KIND_W-1:0] pair_kind(input t_mode m, input logic [7:0] c);
        logic [KIND_W-1:0] k;
        k = TK_END;
        case (m)
            MD_EQ:   if (c == CH_EQ) k = TK_EQEQ;
            MD_BAR:  if (c == CH_BAR) k = TK_OROR;
            MD_AMP:  if (c == CH_AMP) k = TK_ANDAND;
            MD_BANG: if (c == CH_EQ) k = TK_NE;
            MD_LT: begin
                if (c == CH_EQ) k = TK_LE;
                else if (c == CH_LT) k = TK_SHL;
            end
            MD_GT: begin
                if (c == CH_EQ) k = TK_GE;
                else if (c == CH_GT) k = TK_SHR;
            end
            default: k = TK_END;
        endcase
        return k;
    endfunction

endpackage

FILE: rtl/ell_scan.sv
// Scanner state, position counters and per-byte token generation.
module ell_scan #(
    parameter int COUNTER_BITS = ell_pkg::CNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_fin,
    output ell_pkg::t_tok_group o_group
);
    import ell_pkg::*;

    localparam int CB = COUNTER_BITS;

    typedef logic [CB-1:0] t_cnt;
    typedef logic [CB:0]   t_len;

    localparam t_cnt CNT_ONE = CB'(1);
    localparam t_len LEN_ONE = (CB + 1)'(1);

    t_mode r_mode, n_mode;
    t_cnt  r_off, r_line, r_col;
    t_cnt  r_ts_off, r_ts_line, r_ts_col;
    t_cnt  n_ts_off, n_ts_line, n_ts_col;
    logic  r_halt, n_halt;
    t_cnt  adv_off, adv_line, adv_col;
    t_len  len_here, len_fin;
    t_mode mode_start;
    logic [KIND_W-1:0] kind_single, kind_pair;
    logic  do_fresh;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == '1) ? v : v + CNT_ONE;
    endfunction

    function automatic t_token make_tok(input logic [KIND_W-1:0] kind, input t_cnt off,
                                        input t_len len, input t_cnt line, input t_cnt col);
        t_token t;
        t.kind = kind;
        t.off  = FIELD_W'(off);
        t.len  = FIELD_W'(len);
        t.line = FIELD_W'(line);
        t.col  = FIELD_W'(col);
        return t;
    endfunction

    always_comb begin
        adv_off = sat_inc(r_off);
        if (i_byte == CH_LF) begin
            adv_line = sat_inc(r_line);
            adv_col  = CNT_ONE;
        end else begin
            adv_line = r_line;
            adv_col  = sat_inc(r_col);
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_ts_off    = r_ts_off;
        n_ts_line   = r_ts_line;
        n_ts_col    = r_ts_col;
        n_halt      = r_halt;
        o_group     = '0;
        do_fresh    = 1'b0;
        len_here    = {1'b0, r_off} - {1'b0, r_ts_off};
        kind_single = single_kind(i_byte);
        kind_pair   = pair_kind(r_mode, i_byte);
        mode_start  = start_mode(i_byte);

        // slot 0: pending token closed by this byte
        if (!r_halt) begin
            case (r_mode)
                MD_IDLE: do_fresh = 1'b1;
                MD_COMMENT: begin
                    if (i_byte == CH_LF) n_mode = MD_IDLE;
                end
                MD_IDENT, MD_INT: begin
                    if (!(is_digit(i_byte) || (r_mode == MD_IDENT && is_alpha(i_byte)))) begin
                        o_group.vld[0] = 1'b1;
                        o_group.tok[0] = make_tok(lone_kind(r_mode), r_ts_off, len_here,
                                                  r_ts_line, r_ts_col);
                        n_mode   = MD_IDLE;
                        do_fresh = 1'b1;
                    end
                end
                MD_COLON: begin
                    o_group.vld[0] = 1'b1;
                    n_mode = MD_IDLE;
                    if (i_byte == CH_EQ) begin
                        o_group.tok[0] = make_tok(TK_ASSIGN, r_ts_off, len_here + LEN_ONE,
                                                  r_ts_line, r_ts_col);
                    end else begin
                        o_group.tok[0] = make_tok(TK_ERROR, r_ts_off, LEN_ONE,
                                                  r_ts_line, r_ts_col);
                        n_halt = 1'b1;
                    end
                end
                MD_EQ, MD_BAR, MD_AMP, MD_LT, MD_GT, MD_BANG: begin
                    o_group.vld[0] = 1'b1;
                    n_mode = MD_IDLE;
                    if (kind_pair != TK_END) begin
                        o_group.tok[0] = make_tok(kind_pair, r_ts_off, len_here + LEN_ONE,
                                                  r_ts_line, r_ts_col);
                    end else begin
                        o_group.tok[0] = make_tok(lone_kind(r_mode), r_ts_off, len_here,
                                                  r_ts_line, r_ts_col);
                        do_fresh = 1'b1;
                    end
                end
                default: begin
                    n_mode   = MD_IDLE;
                    do_fresh = 1'b1;
                end
            endcase
        end

        // slot 1: token at this byte
        if (do_fresh) begin
            if (kind_single != TK_END) begin
                o_group.vld[1] = 1'b1;
                o_group.tok[1] = make_tok(kind_single, r_off, LEN_ONE, r_line, r_col);
            end else if (i_byte == CH_SEMI) begin
                n_mode = MD_COMMENT;
            end else if (mode_start != MD_IDLE) begin
                n_mode    = mode_start;
                n_ts_off  = r_off;
                n_ts_line = r_line;
                n_ts_col  = r_col;
            end else if (!is_space(i_byte)) begin
                o_group.vld[1] = 1'b1;
                o_group.tok[1] = make_tok(TK_ERROR, r_off, LEN_ONE, r_line, r_col);
                n_halt = 1'b1;
            end
        end

        // end of source: flush the pending token into slot 1, end token in slot 2
        len_fin = {1'b0, adv_off} - {1'b0, n_ts_off};
        if (i_fin) begin
            if (!n_halt && n_mode != MD_IDLE && n_mode != MD_COMMENT) begin
                o_group.vld[1] = 1'b1;
                if (n_mode == MD_COLON) begin
                    o_group.tok[1] = make_tok(TK_ERROR, n_ts_off, LEN_ONE, n_ts_line, n_ts_col);
                end else begin
                    o_group.tok[1] = make_tok(lone_kind(n_mode), n_ts_off, len_fin,
                                              n_ts_line, n_ts_col);
                end
            end
            o_group.vld[2] = 1'b1;
            o_group.tok[2] = make_tok(TK_END, adv_off, '0, adv_line, adv_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_fin)) begin
            r_mode    <= MD_IDLE;
            r_off     <= '0;
            r_line    <= CNT_ONE;
            r_col     <= CNT_ONE;
            r_ts_off  <= '0;
            r_ts_line <= CNT_ONE;
            r_ts_col  <= CNT_ONE;
            r_halt    <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_off     <= adv_off;
            r_line    <= adv_line;
            r_col     <= adv_col;
            r_ts_off  <= n_ts_off;
            r_ts_line <= n_ts_line;
            r_ts_col  <= n_ts_col;
            r_halt    <= n_halt;
        end
    end

endmodule

FILE: rtl/ell_tokbuf.sv
// Three-slot result register that hands out the tokens of one byte in order.
module ell_tokbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ell_pkg::t_tok_group i_group,
    input  logic                i_out_ready,
    output logic                o_load_ok,
    output logic                o_out_valid,
    output ell_pkg::t_token     o_token,
    output logic                o_run_end
);
    import ell_pkg::*;

    logic [SLOTS-1:0]   r_vld;
    t_token [SLOTS-1:0] r_tok;
    logic [1:0]         cur;
    logic [SLOTS-1:0]   cur_bit, above;

    always_comb begin
        if (r_vld[0]) begin
            cur = 2'd0; cur_bit = 3'b001; above = 3'b110;
        end else if (r_vld[1]) begin
            cur = 2'd1; cur_bit = 3'b010; above = 3'b100;
        end else begin
            cur = 2'd2; cur_bit = 3'b100; above = 3'b000;
        end
    end

    assign o_out_valid = |r_vld;
    assign o_token     = r_tok[cur];
    assign o_run_end   = ((r_vld & above) == '0);
    assign o_load_ok   = (r_vld == '0) ||
                         ((r_vld inside {3'b001, 3'b010, 3'b100}) && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_load) begin
            r_vld <= i_group.vld;
        end else if (o_out_valid && i_out_ready) begin
            r_vld <= r_vld & ~cur_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_group.tok;
        end
    end

endmodule

FILE: rtl/expression_language_lexer.sv
// Top level of the streaming expression lexer: input register, scanner and result buffer.
// The lexer takes one source byte per clock while o_in_ready is high, returns zero to three
// tokens for it, one token per clock on the output while i_out_ready is high, with
// o_run_end on the last token of a byte. An accepted byte waits in the input register, is
// scanned against the pending token state and lands in a three-slot result register; the
// next byte is taken in the same cycle as long as the result register holds at most one
// token that leaves then. Bytes that give one token or none thus flow at one byte per
// clock while the output is ready; a byte that gives more holds the input until its last
// token leaves. Position counters saturate at 2^COUNTER_BITS - 1, and all position fields
// show the low 24 bits. The final byte flushes any pending token, emits the end token and resets the lexer.
module expression_language_lexer #(
    parameter int COUNTER_BITS = ell_pkg::CNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_source_byte,
    input  logic                        i_final_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ell_pkg::KIND_W-1:0]  o_token_kind,
    output logic [ell_pkg::FIELD_W-1:0] o_start_offset,
    output logic [ell_pkg::FIELD_W-1:0] o_token_length,
    output logic [ell_pkg::FIELD_W-1:0] o_start_line,
    output logic [ell_pkg::FIELD_W-1:0] o_start_column,
    output logic                        o_run_end
);
    import ell_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_fin;
    logic       step, load_ok;
    t_tok_group group;
    t_token     token;

    assign step       = r_in_valid && load_ok;
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_source_byte;
            r_in_fin  <= i_final_byte;
        end
    end

    ell_scan #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_byte (r_in_byte),
        .i_fin  (r_in_fin),
        .o_group(group)
    );

    ell_tokbuf u_tokbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_group    (group),
        .i_out_ready(i_out_ready),
        .o_load_ok  (load_ok),
        .o_out_valid(o_out_valid),
        .o_token    (token),
        .o_run_end  (o_run_end)
    );

    assign o_token_kind   = token.kind;
    assign o_start_offset = token.off;
    assign o_token_length = token.len;
    assign o_start_line   = token.line;
    assign o_start_column = token.col;

endmodule

FILE: rtl/ell_checker.sv
// Port-level assertions for the lexer and the bind that attaches them.
module ell_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [ell_pkg::KIND_W-1:0]  o_token_kind,
    input logic [ell_pkg::FIELD_W-1:0] o_start_offset,
    input logic [ell_pkg::FIELD_W-1:0] o_token_length,
    input logic [ell_pkg::FIELD_W-1:0] o_start_line,
    input logic [ell_pkg::FIELD_W-1:0] o_start_column,
    input logic                        o_run_end
);
    import ell_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_token_kind) && $stable(o_start_offset)
        && $stable(o_token_length) && $stable(o_start_line) && $stable(o_start_column)
        && $stable(o_run_end))
        else $error("output payload changed while stalled");

    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == TK_END |-> o_token_length == '0 && o_run_end)
        else $error("end token not last or has nonzero length");

    a_error_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == TK_ERROR |-> o_token_length == FIELD_W'(1))
        else $error("error token length is not one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind expression_language_lexer ell_checker u_ell_checker (.*);

FILE: tb/lexer_token_checker.sv
// Token checker for the expression lexer: predicts tokens from accepted bytes and compares.
module lexer_token_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [7:0]                  i_source_byte,
    input  logic                        i_final_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [ell_pkg::KIND_W-1:0]  i_token_kind,
    input  logic [ell_pkg::FIELD_W-1:0] i_start_offset,
    input  logic [ell_pkg::FIELD_W-1:0] i_token_length,
    input  logic [ell_pkg::FIELD_W-1:0] i_start_line,
    input  logic [ell_pkg::FIELD_W-1:0] i_start_column,
    input  logic                        i_run_end,
    output int                          o_fail_count,
    output int                          o_tokens_owed
);
    import ell_pkg::*;

    localparam logic [FIELD_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] off;
        logic [FIELD_W-1:0] len;
        logic [FIELD_W-1:0] line;
        logic [FIELD_W-1:0] col;
        logic               last;
    } lex_token_t;

    t_mode              pend_mode = MD_IDLE;
    logic [FIELD_W-1:0] pos_off   = '0;
    logic [FIELD_W-1:0] pos_line  = 24'd1;
    logic [FIELD_W-1:0] pos_col   = 24'd1;
    logic [FIELD_W-1:0] tok_off   = '0;
    logic [FIELD_W-1:0] tok_line  = 24'd1;
    logic [FIELD_W-1:0] tok_col   = 24'd1;
    logic               halted    = 1'b0;

    lex_token_t step_buf [SLOTS];
    int         step_n;
    lex_token_t expected_tokens [$];
    int         mismatches = 0;

    function automatic logic is_letter_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic is_digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank_byte(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [KIND_W-1:0] one_char_kind(input logic [7:0] c);
        case (c)
            "(":     return TK_LPAREN;
            ")":     return TK_RPAREN;
            ",":     return TK_COMMA;
            "#":     return TK_HASH;
            "+":     return TK_PLUS;
            "-":     return TK_MINUS;
            "*":     return TK_STAR;
            "/":     return TK_SLASH;
            "%":     return TK_PERCENT;
            "~":     return TK_TILDE;
            "^":     return TK_CARET;
            default: return TK_END;
        endcase
    endfunction

    function automatic t_mode opener_mode(input logic [7:0] c);
        case (c)
            CH_EQ:    return MD_EQ;
            CH_COLON: return MD_COLON;
            CH_BAR:   return MD_BAR;
            CH_AMP:   return MD_AMP;
            CH_LT:    return MD_LT;
            CH_GT:    return MD_GT;
            CH_BANG:  return MD_BANG;
            default:  return MD_IDLE;
        endcase
    endfunction

    // kind of a pending token closed by a byte that does not extend it
    function automatic logic [KIND_W-1:0] cut_short_kind(input t_mode m);
        case (m)
            MD_EQ:    return TK_EQ;
            MD_BAR:   return TK_OR;
            MD_AMP:   return TK_AND;
            MD_LT:    return TK_LT;
            MD_GT:    return TK_GT;
            MD_BANG:  return TK_BANG;
            MD_IDENT: return TK_IDENT;
            MD_INT:   return TK_INT;
            default:  return TK_ERROR;
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] bump(input logic [FIELD_W-1:0] v);
        return (v == POS_MAX) ? v : v + 24'd1;
    endfunction

    function automatic void add_token(input logic [KIND_W-1:0] kind,
                                      input logic [FIELD_W-1:0] off,
                                      input logic [FIELD_W-1:0] len,
                                      input logic [FIELD_W-1:0] line,
                                      input logic [FIELD_W-1:0] col);
        if (step_n < SLOTS) begin
            step_buf[step_n] = '{kind, off, len, line, col, 1'b0};
            step_n++;
        end
    endfunction

    function automatic void start_here();
        tok_off  = pos_off;
        tok_line = pos_line;
        tok_col  = pos_col;
    endfunction

    function automatic void restart();
        pend_mode = MD_IDLE;
        pos_off   = '0;
        pos_line  = 24'd1;
        pos_col   = 24'd1;
        tok_off   = '0;
        tok_line  = 24'd1;
        tok_col   = 24'd1;
        halted    = 1'b0;
    endfunction

    // byte seen with nothing pending
    function automatic void open_token(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        t_mode             m;
        k = one_char_kind(c);
        m = opener_mode(c);
        if (k != TK_END) begin
            add_token(k, pos_off, 24'd1, pos_line, pos_col);
        end else if (c == CH_SEMI) begin
            pend_mode = MD_COMMENT;
        end else if (m != MD_IDLE) begin
            pend_mode = m;
            start_here();
        end else if (is_letter_byte(c)) begin
            pend_mode = MD_IDENT;
            start_here();
        end else if (is_digit_byte(c)) begin
            pend_mode = MD_INT;
            start_here();
        end else if (!is_blank_byte(c)) begin
            add_token(TK_ERROR, pos_off, 24'd1, pos_line, pos_col);
            halted = 1'b1;
        end
    endfunction

    function automatic void scan_source_byte(input logic [7:0] c);
        t_mode             m;
        logic [KIND_W-1:0] pair;
        m    = pend_mode;
        pair = TK_END;
        case (m)
            MD_IDLE: begin
                open_token(c);
                return;
            end
            MD_COMMENT: begin
                if (c == CH_LF) pend_mode = MD_IDLE;
                return;
            end
            MD_IDENT: if (is_letter_byte(c) || is_digit_byte(c)) return;
            MD_INT:   if (is_digit_byte(c)) return;
            MD_EQ:    if (c == CH_EQ) pair = TK_EQEQ;
            MD_BAR:   if (c == CH_BAR) pair = TK_OROR;
            MD_AMP:   if (c == CH_AMP) pair = TK_ANDAND;
            MD_BANG:  if (c == CH_EQ) pair = TK_NE;
            MD_LT: begin
                if (c == CH_EQ) pair = TK_LE;
                else if (c == CH_LT) pair = TK_SHL;
            end
            MD_GT: begin
                if (c == CH_EQ) pair = TK_GE;
                else if (c == CH_GT) pair = TK_SHR;
            end
            MD_COLON: begin
                if (c == CH_EQ) begin
                    pair = TK_ASSIGN;
                end else begin
                    // lone colon: error, the following byte is dropped
                    add_token(TK_ERROR, tok_off, 24'd1, tok_line, tok_col);
                    pend_mode = MD_IDLE;
                    halted    = 1'b1;
                    return;
                end
            end
            default: begin
                pend_mode = MD_IDLE;
                open_token(c);
                return;
            end
        endcase
        pend_mode = MD_IDLE;
        if (pair != TK_END) begin
            add_token(pair, tok_off, pos_off + 24'd1 - tok_off, tok_line, tok_col);
        end else begin
            add_token(cut_short_kind(m), tok_off, pos_off - tok_off, tok_line, tok_col);
            open_token(c);
        end
    endfunction

    function automatic void predict_transaction(input logic [7:0] c, input logic fin);
        step_n = 0;
        if (!halted) scan_source_byte(c);
        pos_off = bump(pos_off);
        if (c == CH_LF) begin
            pos_line = bump(pos_line);
            pos_col  = 24'd1;
        end else begin
            pos_col = bump(pos_col);
        end
        if (fin) begin
            if (!halted && pend_mode != MD_IDLE && pend_mode != MD_COMMENT) begin
                if (pend_mode == MD_COLON) begin
                    add_token(TK_ERROR, tok_off, 24'd1, tok_line, tok_col);
                end else begin
                    add_token(cut_short_kind(pend_mode), tok_off, pos_off - tok_off,
                              tok_line, tok_col);
                end
            end
            add_token(TK_END, pos_off, '0, pos_line, pos_col);
            restart();
        end
        if (step_n > 0) step_buf[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_buf[i]);
    endfunction

    always @(posedge i_clk) begin
        lex_token_t seen;
        lex_token_t want;
        if (!i_rst_n) begin
            restart();
            expected_tokens.delete();
        end else begin
            if (i_in_valid && i_in_ready) predict_transaction(i_source_byte, i_final_byte);
            if (i_out_valid && i_out_ready) begin
                seen = '{i_token_kind, i_start_offset, i_token_length, i_start_line,
                         i_start_column, i_run_end};
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token: kind %0d off %0d len %0d ln %0d col %0d end %0b",
                                 seen.kind, seen.off, seen.len, seen.line, seen.col, seen.last);
                end else begin
                    want = expected_tokens.pop_front();
                    if (seen.kind !== want.kind || seen.off !== want.off ||
                        seen.len !== want.len || seen.line !== want.line ||
                        seen.col !== want.col || seen.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("token mismatch: expected kind %0d off %0d len %0d ln %0d col %0d end %0b",
                                     want.kind, want.off, want.len, want.line, want.col,
                                     want.last);
                            $display("                got      kind %0d off %0d len %0d ln %0d col %0d end %0b",
                                     seen.kind, seen.off, seen.len, seen.line, seen.col,
                                     seen.last);
                        end
                    end
                end
            end
        end
        o_fail_count  <= mismatches;
        o_tokens_owed <= expected_tokens.size();
    end

endmodule

FILE: tb/tb_expression_language_lexer.sv
// Testbench top for the expression lexer: byte stimulus, token sink, watchdog and verdict.
module tb_expression_language_lexer;

    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 16;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] src_byte   = 8'd0;
    logic       final_byte = 1'b0;
    logic       out_ready  = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [ell_pkg::KIND_W-1:0]  tok_kind;
    logic [ell_pkg::FIELD_W-1:0] tok_off;
    logic [ell_pkg::FIELD_W-1:0] tok_len;
    logic [ell_pkg::FIELD_W-1:0] tok_line;
    logic [ell_pkg::FIELD_W-1:0] tok_col;
    logic                        tok_last;

    int fail_count;
    int tokens_owed;

    bit hold_go   = 1'b0;
    bit hold_done = 1'b0;
    bit steady    = 1'b0;

    logic [7:0] text_q [$];
    string      single_ops = "(),#+-*/%~^";
    string      pair_ops   = "==:=||&&<=<<>=>>!=";
    string      lone_ops   = "=|&<>!";

    expression_language_lexer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_source_byte  (src_byte),
        .i_final_byte   (final_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_token_kind   (tok_kind),
        .o_start_offset (tok_off),
        .o_token_length (tok_len),
        .o_start_line   (tok_line),
        .o_start_column (tok_col),
        .o_run_end      (tok_last)
    );

    lexer_token_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_source_byte  (src_byte),
        .i_final_byte   (final_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_token_kind   (tok_kind),
        .i_start_offset (tok_off),
        .i_token_length (tok_len),
        .i_start_line   (tok_line),
        .i_start_column (tok_col),
        .i_run_end      (tok_last),
        .o_fail_count   (fail_count),
        .o_tokens_owed  (tokens_owed)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] letter_byte();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return "A" + 8'(r);
        if (r < 52) return "a" + 8'(r - 26);
        return ell_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] alnum_byte();
        if ($urandom_range(0, 3) == 0) return "0" + 8'($urandom_range(0, 9));
        return letter_byte();
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        src_byte   <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_queued();
        for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_owed != 0) @(posedge clk);
    endtask

    // one source built from token-shaped pieces, or a short run of random bytes
    task automatic compose_source();
        int         pieces;
        int         kind;
        int         idx;
        logic [7:0] c;
        text_q.delete();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        pieces = $urandom_range(1, 12);
        repeat (pieces) begin
            kind = $urandom_range(0, 99);
            if (kind < 22) begin
                text_q.push_back(letter_byte());
                repeat ($urandom_range(0, 5)) text_q.push_back(alnum_byte());
            end else if (kind < 36) begin
                repeat ($urandom_range(1, 4)) text_q.push_back("0" + 8'($urandom_range(0, 9)));
            end else if (kind < 50) begin
                text_q.push_back(single_ops[$urandom_range(0, single_ops.len() - 1)]);
            end else if (kind < 62) begin
                idx = 2 * $urandom_range(0, pair_ops.len() / 2 - 1);
                text_q.push_back(pair_ops[idx]);
                text_q.push_back(pair_ops[idx + 1]);
            end else if (kind < 68) begin
                text_q.push_back(lone_ops[$urandom_range(0, lone_ops.len() - 1)]);
            end else if (kind < 84) begin
                repeat ($urandom_range(1, 3)) begin
                    c = 8'($urandom_range(8, 13));
                    text_q.push_back((c == 8'd8) ? " " : c);
                end
            end else if (kind < 90) begin
                text_q.push_back(ell_pkg::CH_SEMI);
                repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 4) != 0) text_q.push_back(ell_pkg::CH_LF);
            end else if (kind < 95) begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 1) == 0) begin
                    text_q.push_back(ell_pkg::CH_COLON);
                    c = 8'($urandom_range(0, 255));
                    text_q.push_back((c == ell_pkg::CH_EQ) ? "x" : c);
                end else begin
                    text_q.push_back(8'($urandom_range(128, 255)));
                end
            end
        end
    endtask

    // token sink: phases of free flow, random stalls, and one long hold-off
    initial begin
        int phase_kind;
        int phase_left;
        phase_kind = 0;
        phase_left = 0;
        forever begin
            if (hold_go && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                if (phase_left == 0) begin
                    phase_kind = $urandom_range(0, 9);
                    phase_left = $urandom_range(4, 40);
                end
                phase_left--;
                if (phase_kind < 4) out_ready <= 1'b1;
                else if (phase_kind < 8) out_ready <= ($urandom_range(0, 3) != 0);
                else if (phase_kind == 8) out_ready <= 1'($urandom_range(0, 1));
                else out_ready <= 1'b0;
                @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int sent;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_text("x:=9;c\n");
        send_text(":a");
        send_text("a=");
        send_text("<");
        send_text(":");
        send_text("\t!=7");
        send_text("Az_09 ");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte("+", 1'b1);
        wait_drained();

        hold_go = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            compose_source();
            steady = ($urandom_range(0, 3) == 0);
            send_queued();
            sent += text_q.size();
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && tokens_owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
